// ----- src/keypad_code_lock_controller_assert.svh -----
// Assertion macros for the keypad code lock controller.
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_ASSERT_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked property, disabled while reset is asserted (active low reset).
`define KCLC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also holds during reset.
`define KCLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KCLC_ASSERT(lbl, clk, rst_n, prop, msg)
`define KCLC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- src/kclc_pkg.sv -----
package kclc_pkg;

  localparam int unsigned CODE_LEN = 8;

  localparam int unsigned KEY_W      = 5;
  localparam int unsigned SYM_W      = 4;
  localparam int unsigned WRONG_W    = 3;
  localparam int unsigned TICKS_W    = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned COUNT_OUT_W = 4;

  localparam logic [WRONG_W-1:0] ERROR_LIMIT_RST   = 3'd3;
  localparam logic [TICKS_W-1:0] LOCKOUT_TICKS_RST = 8'd30;
  localparam logic [WRONG_W-1:0] WRONG_MAX         = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TICKS = 1'd1;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [KEY_W-1:0] KEY_NONE     = 5'd0;
  localparam logic [KEY_W-1:0] KEY_SYM_LAST = 5'd14;
  localparam logic [KEY_W-1:0] KEY_DEL      = 5'd15;
  localparam logic [KEY_W-1:0] KEY_OK       = 5'd16;

  typedef enum logic [1:0] {
    MODE_SET    = 2'd0,
    MODE_LOCKED = 2'd1,
    MODE_OPEN   = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    ST_NONE        = 4'd0,
    ST_SYMBOL      = 4'd1,
    ST_ERASED      = 4'd2,
    ST_CLEARED     = 4'd3,
    ST_STORED      = 4'd4,
    ST_INCOMPLETE  = 4'd5,
    ST_OPENED      = 4'd6,
    ST_WRONG       = 4'd7,
    ST_LOCKOUT     = 4'd8,
    ST_RELOCKED    = 4'd9,
    ST_CODE_ERASED = 4'd10,
    ST_IGNORED     = 4'd11
  } status_e;

  typedef enum logic [1:0] {
    MOTOR_NONE  = 2'd0,
    MOTOR_OPEN  = 2'd1,
    MOTOR_CLOSE = 2'd2
  } motor_e;

  // Scalar lock state (entry count travels separately, its width follows CodeLen)
  typedef struct packed {
    mode_e              mode;
    logic [WRONG_W-1:0] wrong;
    logic [TICKS_W-1:0] lockout;
  } ctl_t;

  // One result word
  typedef struct packed {
    mode_e                  mode;
    logic [COUNT_OUT_W-1:0] count;
    status_e                status;
    motor_e                 motor;
    logic [SYM_W-1:0]       symbol;
    logic                   locked_out;
  } res_t;

endpackage

// ----- src/kclc_step.sv -----
module kclc_step #(
  parameter int unsigned CodeLen = kclc_pkg::CODE_LEN,
  parameter int unsigned CntW    = $clog2(CodeLen + 1),
  parameter int unsigned IdxW    = (CodeLen > 1) ? $clog2(CodeLen) : 1
) (
  input  logic                           cmd_i,
  input  logic [kclc_pkg::KEY_W-1:0]     key_i,
  input  logic                           long_press_i,
  input  logic [kclc_pkg::WRONG_W-1:0]   error_limit_i,
  input  logic [kclc_pkg::TICKS_W-1:0]   lockout_ticks_i,
  input  kclc_pkg::ctl_t                 ctl_i,
  input  logic [CntW-1:0]                cnt_i,
  input  logic [kclc_pkg::SYM_W-1:0]     entry_i [CodeLen],
  input  logic [kclc_pkg::SYM_W-1:0]     code_i  [CodeLen],
  output kclc_pkg::ctl_t                 ctl_o,
  output logic [CntW-1:0]                cnt_o,
  output logic                           buf_we_o,
  output logic [IdxW-1:0]                buf_idx_o,
  output logic [kclc_pkg::SYM_W-1:0]     buf_data_o,
  output logic                           code_store_o,
  output kclc_pkg::res_t                 res_o
);

  localparam logic [CntW-1:0] FullCnt = CntW'(CodeLen);

  logic                          match;
  logic [kclc_pkg::WRONG_W-1:0]  wrong_inc;
  kclc_pkg::status_e             status;
  kclc_pkg::motor_e              motor;
  logic [kclc_pkg::SYM_W-1:0]    sym;

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CodeLen; i++) begin
      if (entry_i[i] != code_i[i]) match = 1'b0;
    end
  end

  // saturating error count
  assign wrong_inc = (ctl_i.wrong < kclc_pkg::WRONG_MAX) ? ctl_i.wrong + 1'b1 : ctl_i.wrong;

  always_comb begin
    ctl_o        = ctl_i;
    cnt_o        = cnt_i;
    buf_we_o     = 1'b0;
    buf_idx_o    = cnt_i[IdxW-1:0];
    buf_data_o   = kclc_pkg::SYM_W'(key_i - 1'b1);
    code_store_o = 1'b0;
    status       = kclc_pkg::ST_IGNORED;
    motor        = kclc_pkg::MOTOR_NONE;
    sym          = '0;

    if (cmd_i == kclc_pkg::CMD_TICK) begin
      if (ctl_i.lockout != '0) ctl_o.lockout = ctl_i.lockout - 1'b1;
      status = kclc_pkg::ST_NONE;
    end else if (ctl_i.lockout != '0 || key_i == kclc_pkg::KEY_NONE ||
                 key_i > kclc_pkg::KEY_OK) begin
      status = kclc_pkg::ST_IGNORED;
    end else if (ctl_i.mode == kclc_pkg::MODE_OPEN) begin
      if (key_i == kclc_pkg::KEY_DEL && long_press_i) begin
        ctl_o.mode  = kclc_pkg::MODE_LOCKED;
        ctl_o.wrong = '0;
        cnt_o       = '0;
        motor       = kclc_pkg::MOTOR_CLOSE;
        status      = kclc_pkg::ST_RELOCKED;
      end else if (key_i == kclc_pkg::KEY_OK && long_press_i) begin
        // stored code is dead from here on; a new one is stored before any compare
        ctl_o.mode = kclc_pkg::MODE_SET;
        cnt_o      = '0;
        motor      = kclc_pkg::MOTOR_CLOSE;
        status     = kclc_pkg::ST_CODE_ERASED;
      end
    end else if (key_i <= kclc_pkg::KEY_SYM_LAST) begin
      if (cnt_i < FullCnt) begin
        buf_we_o = 1'b1;
        cnt_o    = cnt_i + 1'b1;
        sym      = buf_data_o;
        status   = kclc_pkg::ST_SYMBOL;
      end
    end else if (key_i == kclc_pkg::KEY_DEL) begin
      if (cnt_i != '0) begin
        if (long_press_i) begin
          cnt_o  = '0;
          status = kclc_pkg::ST_CLEARED;
        end else begin
          cnt_o  = cnt_i - 1'b1;
          status = kclc_pkg::ST_ERASED;
        end
      end
    end else if (!long_press_i) begin
      if (ctl_i.mode == kclc_pkg::MODE_SET) begin
        if (cnt_i == FullCnt) begin
          code_store_o = 1'b1;
          ctl_o.mode   = kclc_pkg::MODE_LOCKED;
          ctl_o.wrong  = '0;
          cnt_o        = '0;
          status       = kclc_pkg::ST_STORED;
        end else begin
          status = kclc_pkg::ST_INCOMPLETE;
        end
      end else begin
        if (cnt_i < FullCnt) begin
          status = kclc_pkg::ST_INCOMPLETE;
        end else if (match) begin
          ctl_o.mode  = kclc_pkg::MODE_OPEN;
          ctl_o.wrong = '0;
          motor       = kclc_pkg::MOTOR_OPEN;
          status      = kclc_pkg::ST_OPENED;
        end else if (wrong_inc >= error_limit_i) begin
          ctl_o.lockout = lockout_ticks_i;
          ctl_o.wrong   = wrong_inc - 1'b1;
          status        = kclc_pkg::ST_LOCKOUT;
        end else begin
          ctl_o.wrong = wrong_inc;
          status      = kclc_pkg::ST_WRONG;
        end
        cnt_o = '0;
      end
    end
  end

  always_comb begin
    res_o.mode       = ctl_o.mode;
    res_o.count      = kclc_pkg::COUNT_OUT_W'(cnt_o);
    res_o.status     = status;
    res_o.motor      = motor;
    res_o.symbol     = sym;
    res_o.locked_out = (ctl_o.lockout != '0);
  end

endmodule

// ----- src/keypad_code_lock_controller.sv -----
// Keypad code lock controller.
// Input channel (in_valid_i / in_stall_o): one word per event, cmd_i = 0 for a key
// press (key_i 1..16, long_press_i) or cmd_i = 1 for a timer tick.
// Output channel (out_valid_o / out_stall_i): exactly one result word per input
// word, in order: mode, entered count, status, bolt motor command, symbol and the
// lockout flag, all as they stand after the event.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 error limit,
// 1 lockout length in ticks); write only while no word is in flight.
// Path: an accepted word is registered in the input register, then processed into
// the result register, from which it is taken.
// Throughput: one word per cycle while the output is not stalled; the whole event
// is one pass of next-state logic between the input register and the result
// register, including the 8-symbol code compare.
// Stall: a stalled result holds; the input register still fills behind it, and
// in_stall_o rises only while both registers are full and the output is stalled.
// Reset: setting mode, empty entry, error count and lockout cleared, error limit
// 3, lockout 30 ticks; both channels empty.
`include "keypad_code_lock_controller_assert.svh"

module keypad_code_lock_controller #(
  parameter int unsigned CodeLen = kclc_pkg::CODE_LEN
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [kclc_pkg::KEY_W-1:0]        key_i,
  input  logic                              long_press_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        mode_o,
  output logic [kclc_pkg::COUNT_OUT_W-1:0]  entered_count_o,
  output logic [3:0]                        status_o,
  output logic [1:0]                        motor_cmd_o,
  output logic [kclc_pkg::SYM_W-1:0]        symbol_o,
  output logic                              locked_out_o,
  input  logic                              cfg_we_i,
  input  logic [kclc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [kclc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned CntW = $clog2(CodeLen + 1);
  localparam int unsigned IdxW = (CodeLen > 1) ? $clog2(CodeLen) : 1;

  // config registers
  logic [kclc_pkg::WRONG_W-1:0] error_limit_q;
  logic [kclc_pkg::TICKS_W-1:0] lockout_ticks_q;

  // input register
  logic                         in_valid_q, in_valid_d;
  logic                         cmd_q;
  logic [kclc_pkg::KEY_W-1:0]   key_q;
  logic                         lp_q;
  logic                         in_accept;
  logic                         advance;

  // lock state
  kclc_pkg::ctl_t               ctl_q, ctl_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [kclc_pkg::SYM_W-1:0]   entry_q [CodeLen];
  logic [kclc_pkg::SYM_W-1:0]   code_q  [CodeLen];

  logic                         buf_we;
  logic [IdxW-1:0]              buf_idx;
  logic [kclc_pkg::SYM_W-1:0]   buf_data;
  logic                         code_store;

  // result register
  logic                         out_valid_q, out_valid_d;
  kclc_pkg::res_t               res_d, res_q;

  // the event in the input register moves on whenever the result slot is free
  // or being emptied this cycle
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  kclc_step #(
    .CodeLen (CodeLen),
    .CntW    (CntW),
    .IdxW    (IdxW)
  ) u_step (
    .cmd_i           (cmd_q),
    .key_i           (key_q),
    .long_press_i    (lp_q),
    .error_limit_i   (error_limit_q),
    .lockout_ticks_i (lockout_ticks_q),
    .ctl_i           (ctl_q),
    .cnt_i           (cnt_q),
    .entry_i         (entry_q),
    .code_i          (code_q),
    .ctl_o           (ctl_d),
    .cnt_o           (cnt_d),
    .buf_we_o        (buf_we),
    .buf_idx_o       (buf_idx),
    .buf_data_o      (buf_data),
    .code_store_o    (code_store),
    .res_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_limit_q   <= kclc_pkg::ERROR_LIMIT_RST;
      lockout_ticks_q <= kclc_pkg::LOCKOUT_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kclc_pkg::CFG_ERROR_LIMIT: begin
          error_limit_q <= cfg_data_i[kclc_pkg::WRONG_W-1:0];
        end
        kclc_pkg::CFG_LOCKOUT_TICKS: begin
          lockout_ticks_q <= cfg_data_i[kclc_pkg::TICKS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctl_q       <= '{mode: kclc_pkg::MODE_SET, wrong: '0, lockout: '0};
      cnt_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        ctl_q <= ctl_d;
        cnt_q <= cnt_d;
      end
    end
  end

  // payload: input word, entry buffer, stored code, result word
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= cmd_i;
      key_q <= key_i;
      lp_q  <= long_press_i;
    end
    if (advance) begin
      res_q <= res_d;
      if (buf_we) entry_q[buf_idx] <= buf_data;
      if (code_store) code_q <= entry_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mode_o          = res_q.mode;
  assign entered_count_o = res_q.count;
  assign status_o        = res_q.status;
  assign motor_cmd_o     = res_q.motor;
  assign symbol_o        = res_q.symbol;
  assign locked_out_o    = res_q.locked_out;

  // a held result always matches the state it was computed into
  `KCLC_ASSERT(a_lockout_flag, clk_i, rst_ni, out_valid_q |-> (res_q.locked_out == (ctl_q.lockout != '0)), "locked_out disagrees with lockout timer")
  // lockout is only ever entered from locked mode, and keys are dead during it
  `KCLC_ASSERT_ALWAYS(a_lockout_mode, clk_i, (ctl_q.lockout != '0) |-> (ctl_q.mode == kclc_pkg::MODE_LOCKED), "lockout outside locked mode")
  // opening always drives the bolt and lands in open mode
  `KCLC_ASSERT(a_open_motor, clk_i, rst_ni, (out_valid_q && res_q.status == kclc_pkg::ST_OPENED) |-> (res_q.motor == kclc_pkg::MOTOR_OPEN && res_q.mode == kclc_pkg::MODE_OPEN), "open without bolt command")
  // state moves only with a word going into the result register
  `KCLC_ASSERT(a_state_hold, clk_i, rst_ni, !advance |=> ($stable(ctl_q) && $stable(cnt_q)), "state changed without an event")

endmodule
